[hw/rtl/stm_pkg.sv]
// shared types and constants for the sparse table range maximum block
// used by stm_ctrl, stm_dp and sparse_table_range_max_top; no dependencies
package stm_pkg;

  localparam int PRI_W       = 31;
  localparam int POS_W       = 10;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int LEVELS_DEF    = 11;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // how the pending result gets filled
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_BAD,
    RES_PICK
  } res_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic app_init;
    logic app_step;
    logic q_check;
    logic q_read_a;
    logic q_read_b;
    res_e res;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              first_more;
    logic              lvl_more;
    logic              bad;
    logic              out_busy;
  } dp_stat_t;

endpackage

[hw/rtl/stm_ctrl.sv]
// controller state machine for the sparse table range maximum block
// depends on stm_pkg; drives stm_dp through dp_cmd_t, reads dp_stat_t
module stm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  stm_pkg::dp_stat_t stat_i,
  output stm_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_APP_INIT = 4'd2;
  localparam logic [3:0] S_APP_LVL  = 4'd3;
  localparam logic [3:0] S_QRY_CHK  = 4'd4;
  localparam logic [3:0] S_QRY_RDA  = 4'd5;
  localparam logic [3:0] S_QRY_RDB  = 4'd6;
  localparam logic [3:0] S_QRY_PICK = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.mode)
          stm_pkg::MODE_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res = stm_pkg::RES_FULL;
              state_d   = S_FIN;
            end else begin
              state_d = S_APP_INIT;
            end
          end
          stm_pkg::MODE_QUERY: begin
            state_d = S_QRY_CHK;
          end
          stm_pkg::MODE_CLEAR: begin
            cmd_o.clear = 1'b1;
            cmd_o.res   = stm_pkg::RES_OK;
            state_d     = S_FIN;
          end
          default: begin
            cmd_o.res = stm_pkg::RES_OK;
            state_d   = S_FIN;
          end
        endcase
      end
      S_APP_INIT: begin
        cmd_o.app_init = 1'b1;
        if (stat_i.first_more) begin
          state_d = S_APP_LVL;
        end else begin
          cmd_o.res = stm_pkg::RES_OK;
          state_d   = S_FIN;
        end
      end
      S_APP_LVL: begin
        cmd_o.app_step = 1'b1;
        if (!stat_i.lvl_more) begin
          cmd_o.res = stm_pkg::RES_OK;
          state_d   = S_FIN;
        end
      end
      S_QRY_CHK: begin
        cmd_o.q_check = 1'b1;
        state_d       = S_QRY_RDA;
      end
      S_QRY_RDA: begin
        if (stat_i.bad) begin
          cmd_o.res = stm_pkg::RES_BAD;
          state_d   = S_FIN;
        end else begin
          cmd_o.q_read_a = 1'b1;
          state_d        = S_QRY_RDB;
        end
      end
      S_QRY_RDB: begin
        cmd_o.q_read_b = 1'b1;
        state_d        = S_QRY_PICK;
      end
      S_QRY_PICK: begin
        cmd_o.res = stm_pkg::RES_PICK;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/stm_dp.sv]
// datapath: item count, sparse table memory, level walk, query check and
// output register; depends on stm_pkg, commanded by stm_ctrl
module stm_dp #(
  parameter int MAX_ITEMS = stm_pkg::MAX_ITEMS_DEF,
  parameter int LEVELS    = stm_pkg::LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [stm_pkg::MODE_W-1:0]    mode_i,
  input  logic [stm_pkg::PRI_W-1:0]     pri_i,
  input  logic [stm_pkg::POS_W-1:0]     left_i,
  input  logic [stm_pkg::POS_W-1:0]     right_i,
  input  logic                          m_ready_i,
  input  stm_pkg::dp_cmd_t              cmd_i,
  output stm_pkg::dp_stat_t             stat_o,
  output logic                          m_valid_o,
  output logic [stm_pkg::POS_W-1:0]     res_pos_o,
  output logic [stm_pkg::PRI_W-1:0]     res_pri_o,
  output logic [stm_pkg::STATUS_W-1:0]  res_status_o
);

  localparam int PRI_W = stm_pkg::PRI_W;
  localparam int POS_W = stm_pkg::POS_W;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int LVW   = $clog2(LEVELS);
  localparam int ADW   = LVW + AW;
  localparam int EW    = AW + PRI_W;
  localparam int DEPTH = LEVELS * (2 ** AW);
  localparam int LENW  = POS_W + 1;
  localparam int KW    = $clog2(LENW);

  // entry = {position, priority}; address = {level, window start}
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_q, cur_q;
  logic [ADW-1:0] mem_ra, mem_wa;
  logic [EW-1:0]  mem_wd;
  logic           mem_we;

  logic [stm_pkg::MODE_W-1:0] mode_q;
  logic [PRI_W-1:0]           pri_q;
  logic [POS_W-1:0]           left_q, right_q;
  logic [CW-1:0]              count_q, start_q, step, next_start;
  logic [LVW-1:0]             lvl_q, k_q;
  logic [AW-1:0]              s2_q;
  logic                       bad_q;

  logic [POS_W-1:0]              pend_pos_q, res_pos_q;
  logic [PRI_W-1:0]              pend_pri_q, res_pri_q;
  logic [stm_pkg::STATUS_W-1:0]  pend_status_q, res_status_q;
  logic                          out_valid_q;

  logic [EW-1:0]   win_app, win_qry;
  logic [LENW-1:0] lft, rgt, len, s2;
  logic [KW-1:0]   k;
  logic            bad, lvl_more;

  // earlier half (memory) wins only if strictly greater
  assign win_app = (rd_q[PRI_W-1:0] > cur_q[PRI_W-1:0]) ? rd_q : cur_q;
  // left window (held in cur) wins only if strictly greater
  assign win_qry = (cur_q[PRI_W-1:0] > rd_q[PRI_W-1:0]) ? cur_q : rd_q;

  assign step       = CW'(32'd1 << lvl_q);
  assign next_start = start_q - step;
  assign lvl_more   = ((int'(lvl_q) + 1) < LEVELS) && (32'(start_q) >= (32'd1 << lvl_q));

  // query range check and window size
  always_comb begin
    lft = LENW'(left_q);
    rgt = LENW'(right_q);
    len = rgt - lft + LENW'(1);
    k   = '0;
    for (int i = 0; i < LENW; i++) begin
      if (len[i]) begin
        k = KW'(i);
      end
    end
    s2  = rgt + LENW'(1) - (LENW'(1) << k);
    bad = (left_q > right_q) || (32'(right_q) >= 32'(count_q)) || (int'(k) >= LEVELS);
  end

  // memory port selection
  always_comb begin
    mem_ra = '0;
    mem_wa = '0;
    mem_wd = '0;
    mem_we = 1'b0;
    if (cmd_i.app_init) begin
      mem_ra = {LVW'(0), AW'(count_q - CW'(1))};
      mem_wa = {LVW'(0), AW'(count_q)};
      mem_wd = {AW'(count_q), pri_q};
      mem_we = 1'b1;
    end else if (cmd_i.app_step) begin
      mem_ra = {lvl_q, AW'(next_start)};
      mem_wa = {lvl_q, AW'(start_q)};
      mem_wd = win_app;
      mem_we = 1'b1;
    end else if (cmd_i.q_read_a) begin
      mem_ra = {k_q, AW'(left_q)};
    end else if (cmd_i.q_read_b) begin
      mem_ra = {k_q, s2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= stm_pkg::MODE_APPEND;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        mode_q <= mode_i;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.app_init) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pri_q   <= pri_i;
      left_q  <= left_i;
      right_q <= right_i;
    end
    if (cmd_i.app_init) begin
      cur_q   <= {AW'(count_q), pri_q};
      start_q <= count_q - CW'(1);
      lvl_q   <= LVW'(1);
    end
    if (cmd_i.app_step) begin
      cur_q   <= win_app;
      start_q <= next_start;
      lvl_q   <= lvl_q + LVW'(1);
    end
    if (cmd_i.q_check) begin
      k_q   <= LVW'(k);
      s2_q  <= AW'(s2);
      bad_q <= bad;
    end
    if (cmd_i.q_read_b) begin
      cur_q <= rd_q;
    end
    case (cmd_i.res)
      stm_pkg::RES_OK: begin
        pend_pos_q    <= '0;
        pend_pri_q    <= '0;
        pend_status_q <= stm_pkg::ST_OK;
      end
      stm_pkg::RES_FULL: begin
        pend_pos_q    <= '0;
        pend_pri_q    <= '0;
        pend_status_q <= stm_pkg::ST_FULL;
      end
      stm_pkg::RES_BAD: begin
        pend_pos_q    <= '0;
        pend_pri_q    <= '0;
        pend_status_q <= stm_pkg::ST_BAD_RANGE;
      end
      stm_pkg::RES_PICK: begin
        pend_pos_q    <= POS_W'(win_qry[EW-1:PRI_W]);
        pend_pri_q    <= win_qry[PRI_W-1:0];
        pend_status_q <= stm_pkg::ST_OK;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      res_pos_q    <= pend_pos_q;
      res_pri_q    <= pend_pri_q;
      res_status_q <= pend_status_q;
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.full       = int'(count_q) >= MAX_ITEMS;
  assign stat_o.first_more = count_q != '0;
  assign stat_o.lvl_more   = lvl_more;
  assign stat_o.bad        = bad_q;
  assign stat_o.out_busy   = out_valid_q && !m_ready_i;

  assign m_valid_o    = out_valid_q;
  assign res_pos_o    = res_pos_q;
  assign res_pri_o    = res_pri_q;
  assign res_status_o = res_status_q;

endmodule

[hw/rtl/sparse_table_range_max_top.sv]
// top level of the sparse table range maximum block
// depends on stm_pkg; instantiates stm_ctrl and stm_dp
//
// usage
// - slave stream takes one request at a time: tuser is the kind (append,
//   query, clear), tdata carries priority and the inclusive position range
// - master stream returns exactly one result per request: position and
//   priority of the maximum in tdata, status code in tuser
// - append stores the priority at the next position and fills every table
//   level whose window ends there, one read-compare-write per level
// - the table memory has a single read port, and an append walks its
//   levels one level per cycle
// - the result sits in an output register; a new request is accepted while
//   it waits, and the next result waits in the datapath until it is taken
// - reset empties the list and drops any result; the table memory is not
//   cleared, entries are only read after an append has written them
// - a stalled receiver holds the result and tdata/tuser stay stable
module sparse_table_range_max_top #(
  parameter int MAX_ITEMS = stm_pkg::MAX_ITEMS_DEF,
  parameter int LEVELS    = stm_pkg::LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [30:0] priority_req, [40:31] range_left, [50:41] range_right, rest zero
  input  logic [stm_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [stm_pkg::MODE_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [9:0] max_position, [40:10] max_priority, rest zero
  output logic [stm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [stm_pkg::STATUS_W-1:0]     m_axis_tuser_o
);

  localparam int PRI_W   = stm_pkg::PRI_W;
  localparam int POS_W   = stm_pkg::POS_W;
  localparam int OUT_PAD = stm_pkg::OUT_TDATA_W - PRI_W - POS_W;

  stm_pkg::dp_cmd_t  dp_cmd;
  stm_pkg::dp_stat_t dp_stat;

  logic [POS_W-1:0] res_pos;
  logic [PRI_W-1:0] res_pri;

  // control: one request in flight, walks the levels of an append
  stm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  // datapath: request fields unpacked straight from tdata
  stm_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (s_axis_tuser_i),
    .pri_i        (s_axis_tdata_i[PRI_W-1:0]),
    .left_i       (s_axis_tdata_i[PRI_W+POS_W-1:PRI_W]),
    .right_i      (s_axis_tdata_i[PRI_W+2*POS_W-1:PRI_W+POS_W]),
    .m_ready_i    (m_axis_tready_i),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .m_valid_o    (m_axis_tvalid_o),
    .res_pos_o    (res_pos),
    .res_pri_o    (res_pri),
    .res_status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, res_pri, res_pos};

`ifndef SYNTH
  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  // a result is only loaded into a free output slot
  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten before it was taken");

  // loading a result makes it visible on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

  // error results carry zero position and priority
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != stm_pkg::ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("error result with nonzero data");
`endif

endmodule

[tb/sv/rmq_monitor.sv]
// range maximum monitor: follows both streams of the sparse table block,
// keeps its own copy of the list and the table, and checks every result
// depends on stm_pkg for widths, request kinds and status codes
`timescale 1ns / 100ps

module rmq_monitor #(
  parameter int MAX_ITEMS = stm_pkg::MAX_ITEMS_DEF,
  parameter int LEVELS    = stm_pkg::LEVELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  logic [stm_pkg::IN_TDATA_W-1:0]  req_data_i,
  input  logic [stm_pkg::MODE_W-1:0]      req_kind_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [stm_pkg::OUT_TDATA_W-1:0] res_data_i,
  input  logic [stm_pkg::STATUS_W-1:0]    res_status_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int PRI_W    = stm_pkg::PRI_W;
  localparam int POS_W    = stm_pkg::POS_W;
  localparam int MODE_W   = stm_pkg::MODE_W;
  localparam int STATUS_W = stm_pkg::STATUS_W;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [PRI_W-1:0]    prio;
    logic [STATUS_W-1:0] status;
  } range_answer_t;

  logic [PRI_W-1:0] prio_mem [MAX_ITEMS];
  // position of the maximum over 2^level positions starting at the index
  logic [POS_W-1:0] window_best [MAX_ITEMS][LEVELS];
  int unsigned      stored = 0;
  range_answer_t    due_answers [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // later candidate wins unless the earlier one is strictly higher
  function automatic logic [POS_W-1:0] heavier(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    return (prio_mem[a] > prio_mem[b]) ? a : b;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count_o++;
    $display("%0t ns  mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic predict_request(input logic [MODE_W-1:0] kind,
                                 input logic [PRI_W-1:0] prio,
                                 input logic [POS_W-1:0] lft,
                                 input logic [POS_W-1:0] rgt);
    range_answer_t ans;
    int unsigned   p, j, span, s, len, k, s2;
    logic [POS_W-1:0] m;
    ans = '0;
    ans.status = stm_pkg::ST_OK;
    case (kind)
      stm_pkg::MODE_APPEND: begin
        if (stored >= MAX_ITEMS) begin
          ans.status = stm_pkg::ST_FULL;
        end else begin
          p = stored;
          prio_mem[p] = prio;
          window_best[p][0] = p[POS_W-1:0];
          for (j = 1; j < LEVELS && p + 1 >= (1 << j); j++) begin
            span = 1 << j;
            s = p + 1 - span;
            window_best[s][j] = heavier(window_best[s][j-1], window_best[s + span/2][j-1]);
          end
          stored = p + 1;
        end
      end
      stm_pkg::MODE_QUERY: begin
        if (lft > rgt || rgt >= stored) begin
          ans.status = stm_pkg::ST_BAD_RANGE;
        end else begin
          len = rgt - lft + 1;
          k = 0;
          while ((len >> (k + 1)) != 0) k++;
          if (k >= LEVELS) begin
            ans.status = stm_pkg::ST_BAD_RANGE;
          end else begin
            s2 = rgt + 1 - (1 << k);
            m = heavier(window_best[lft][k], window_best[s2][k]);
            ans.pos  = m;
            ans.prio = prio_mem[m];
          end
        end
      end
      stm_pkg::MODE_CLEAR: stored = 0;
      default: ;
    endcase
    due_answers.push_back(ans);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : follow_streams
    range_answer_t want;
    if (!rst_ni) begin
      stored = 0;
      due_answers.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (due_answers.size() == 0) begin
          report_mismatch("result with no request waiting", 64'(res_data_i), 64'(0));
        end else begin
          want = due_answers.pop_front();
          if (res_data_i[POS_W-1:0] !== want.pos)
            report_mismatch("max_position", 64'(res_data_i[POS_W-1:0]), 64'(want.pos));
          if (res_data_i[POS_W+PRI_W-1:POS_W] !== want.prio)
            report_mismatch("max_priority", 64'(res_data_i[POS_W+PRI_W-1:POS_W]),
                            64'(want.prio));
          if (res_status_i !== want.status)
            report_mismatch("status", 64'(res_status_i), 64'(want.status));
        end
      end
      if (req_valid_i && req_ready_i)
        predict_request(req_kind_i, req_data_i[PRI_W-1:0],
                        req_data_i[PRI_W+POS_W-1:PRI_W],
                        req_data_i[PRI_W+2*POS_W-1:PRI_W+POS_W]);
    end
    pending_o = due_answers.size();
  end

endmodule

[tb/sv/testbench.sv]
// top of the sparse table range maximum testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict
// depends on stm_pkg, sparse_table_range_max_top and rmq_monitor
`timescale 1ns / 100ps

module testbench;

  localparam int PRI_W      = stm_pkg::PRI_W;
  localparam int POS_W      = stm_pkg::POS_W;
  localparam int MODE_W     = stm_pkg::MODE_W;
  localparam int IN_TDATA_W = stm_pkg::IN_TDATA_W;
  localparam int MAX_ITEMS  = stm_pkg::MAX_ITEMS_DEF;

  // kind code the block leaves unused, must answer all zeros
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int ITEM_GOAL   = 1850;
  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int DRAIN       = 40;     // settle time after the last result
  localparam int CALM_FROM   = 7000;   // window where neither side idles
  localparam int CALM_TO     = 11000;
  localparam int HOLD_START  = 3000;   // long receiver hold-off
  localparam int HOLD_LEN    = 500;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_ITEMS - 1);
  localparam logic [POS_W-1:0] MID_POS  = POS_W'(MAX_ITEMS / 2);

  logic                               clk;
  logic                               rst_n    = 1'b0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [IN_TDATA_W-1:0]              s_tdata  = '0;
  logic [MODE_W-1:0]                  s_tuser  = stm_pkg::MODE_APPEND;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [stm_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic [stm_pkg::STATUS_W-1:0]       m_tuser;

  int  fail_count;
  int  pending;
  int  cyc      = 0;
  int  sent     = 0;
  int  list_len = 0;   // list length as the stimulus sees it, only for shaping ranges
  wire calm     = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  sparse_table_range_max_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  rmq_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_kind_i   (s_tuser),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .res_status_i (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle count, read only at falling edges
  always @(posedge clk) cyc <= cyc + 1;

  // priorities lean toward ties and the extremes
  function automatic logic [PRI_W-1:0] rand_prio();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0:       return PRI_W'($urandom_range(0, 3));
      1:       return '1;
      2:       return '0;
      default: return w[PRI_W-1:0];
    endcase
  endfunction

  // random position bits for fields the block ignores
  function automatic logic [POS_W-1:0] rand_pos();
    logic [31:0] w;
    w = $urandom();
    return w[POS_W-1:0];
  endfunction

  // one request on the slave stream; returns at the falling edge after the accept
  // with tvalid still high; outside the calm window it may drop before the next request
  task automatic offer(input logic [MODE_W-1:0] kind, input logic [PRI_W-1:0] prio,
                       input logic [POS_W-1:0] lft, input logic [POS_W-1:0] rgt);
    while (!calm && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - PRI_W - 2*POS_W){1'b0}}, rgt, lft, prio};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (kind == stm_pkg::MODE_APPEND && list_len < MAX_ITEMS) list_len++;
    else if (kind == stm_pkg::MODE_CLEAR) list_len = 0;
    @(negedge clk);
  endtask

  // range fields of an append are don't-care, fill them with noise
  task automatic append_prio(input logic [PRI_W-1:0] prio);
    offer(stm_pkg::MODE_APPEND, prio, rand_pos(), rand_pos());
  endtask

  task automatic ask_range(input logic [POS_W-1:0] lft, input logic [POS_W-1:0] rgt);
    offer(stm_pkg::MODE_QUERY, rand_prio(), lft, rgt);
  endtask

  // mostly ranges inside the list, some short ones, the rest raw noise
  task automatic random_query();
    int unsigned l, r;
    if (list_len > 0 && $urandom_range(0, 4) != 0) begin
      r = $urandom_range(0, list_len - 1);
      if ($urandom_range(0, 3) == 0) l = (r > 3) ? r - $urandom_range(0, 3) : 0;
      else l = $urandom_range(0, r);
    end else begin
      r = $urandom_range(0, MAX_ITEMS - 1);
      l = $urandom_range(0, MAX_ITEMS - 1);
    end
    ask_range(l[POS_W-1:0], r[POS_W-1:0]);
  endtask

  // result side: random stalls, one long hold-off that backs the block up,
  // and a calm window with tready held high
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (cyc == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, extreme priorities, ties, bad ranges, spare kind
    ask_range(0, 0);                       // nothing stored yet
    append_prio('0);
    append_prio('1);
    append_prio('1);                       // ties the previous maximum
    append_prio(31'd5);
    append_prio('0);
    ask_range(0, 0);
    ask_range(0, 4);                       // tie between positions 1 and 2, later one wins
    ask_range(1, 2);                       // tie inside one level-1 window
    ask_range(4, 4);
    ask_range(2, 4);
    ask_range(3, 1);                       // left past right
    ask_range(0, 5);                       // right end past the list
    ask_range(LAST_POS, LAST_POS);
    offer(MODE_SPARE, rand_prio(), rand_pos(), rand_pos());
    offer(stm_pkg::MODE_CLEAR, rand_prio(), rand_pos(), rand_pos());
    ask_range(0, 0);                       // list is empty again
    append_prio(rand_prio());
    ask_range(0, 0);

    // fill the whole list with queries in between, then push it past full
    offer(stm_pkg::MODE_CLEAR, rand_prio(), rand_pos(), rand_pos());
    repeat (MAX_ITEMS) begin
      append_prio(rand_prio());
      if ($urandom_range(0, 5) == 0) random_query();
    end
    repeat (3) append_prio(rand_prio());   // append to a full list
    ask_range(0, LAST_POS);                // widest window the table holds
    ask_range(LAST_POS, LAST_POS);
    ask_range(0, LAST_POS - POS_W'(1));
    ask_range(MID_POS, LAST_POS);
    ask_range(1, LAST_POS);

    // random sequences: usually a clear, appends with queries mixed in,
    // a burst of queries, now and then a spare-kind request as noise
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(0, 3) != 0)
        offer(stm_pkg::MODE_CLEAR, rand_prio(), rand_pos(), rand_pos());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      repeat (n) begin
        append_prio(rand_prio());
        if ($urandom_range(0, 2) == 0) random_query();
      end
      repeat ($urandom_range(2, 12)) random_query();
      if ($urandom_range(0, 4) == 0) offer(MODE_SPARE, rand_prio(), rand_pos(), rand_pos());
    end
    s_tvalid <= 1'b0;

    // drain every outstanding result, then let the block settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
